// File: design/lfu_pkg.sv
// lfu_pkg: shared types and constants for the LFU cache table.
// Used by lfu_ctrl, lfu_dpath and lfu_cache_table; depends on nothing.
`default_nettype none

package lfu_pkg;

   localparam int ENTRIES_DEF     = 16;
   localparam int COUNT_WIDTH_DEF = 16;
   localparam int DATA_W          = 32;
   localparam int CFG_W           = 5;

   localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

   typedef enum logic {
      MODE_GET = 1'b0,
      MODE_SET = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [DATA_W-1:0]  key;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [DATA_W-1:0]  read_value;
      logic                      evicted;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic scan_rd;
      logic finish;
      logic cfg_wr;
   } ctl_cmd_type;

   typedef struct packed {
      logic rsp_pending;
   } dp_status_type;

endpackage

`default_nettype wire

// File: design/lfu_ctrl.sv
// lfu_ctrl: sequencer for one lookup/update beat: accept, scan, drain, finish.
// Depends on lfu_pkg; drives lfu_dpath through command signals.
`default_nettype none

module lfu_ctrl #(
   parameter  int ENTRIES = lfu_pkg::ENTRIES_DEF,
   localparam int IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  rsp_stall,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  lfu_pkg::dp_status_type status,
   output lfu_pkg::ctl_cmd_type  cmd,
   output logic [IdxW-1:0]       scan_addr
);
   import lfu_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

   state_type       state_ff;
   state_type       state_in;
   logic [IdxW-1:0] scan_cnt_ff;
   logic [IdxW-1:0] scan_cnt_in;
   logic            out_free;

   assign out_free  = !status.rsp_pending || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign scan_addr = scan_cnt_ff;

   always_comb begin
      cmd.start   = (state_ff == S_IDLE) && req_valid;
      cmd.scan_rd = (state_ff == S_SCAN);
      cmd.finish  = (state_ff == S_FINISH) && out_free;
      cmd.cfg_wr  = (state_ff == S_IDLE) && csr_valid;
   end

   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            scan_cnt_in = '0;
            if (req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_cnt_ff == LastIdx) begin
               state_in = S_DRAIN;
            end else begin
               scan_cnt_in = scan_cnt_ff + IdxW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         scan_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: design/lfu_dpath.sv
// lfu_dpath: key/value/count memories, rank and valid cells, scan accumulators,
// update logic, capacity register and result register. Depends on lfu_pkg.
`default_nettype none

module lfu_dpath #(
   parameter  int ENTRIES     = lfu_pkg::ENTRIES_DEF,
   parameter  int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF,
   localparam int IdxW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lfu_pkg::ctl_cmd_type        cmd,
   input  logic [IdxW-1:0]             scan_addr,
   output lfu_pkg::dp_status_type      status,
   input  lfu_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lfu_pkg::rsp_type            rsp_data,
   input  logic [lfu_pkg::CFG_W-1:0]   csr_data
);
   import lfu_pkg::*;

   localparam int OccW = $clog2(ENTRIES + 1);
   localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
   localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

   logic [DATA_W-1:0]      key_mem [ENTRIES];
   logic [DATA_W-1:0]      val_mem [ENTRIES];
   logic [COUNT_WIDTH-1:0] cnt_mem [ENTRIES];

   logic [IdxW-1:0]        rank_ff [ENTRIES];
   logic [ENTRIES-1:0]     valid_ff;
   logic [OccW-1:0]        occ_ff;
   logic [CFG_W-1:0]       cap_ff;

   req_type                req_ff;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;

   logic [DATA_W-1:0]      key_rd_ff;
   logic [DATA_W-1:0]      val_rd_ff;
   logic [COUNT_WIDTH-1:0] cnt_rd_ff;
   logic                   ev_valid_ff;
   logic [IdxW-1:0]        ev_idx_ff;

   logic                   hit_ff;
   logic [IdxW-1:0]        hit_slot_ff;
   logic [COUNT_WIDTH-1:0] hit_cnt_ff;
   logic [IdxW-1:0]        hit_rank_ff;
   logic [DATA_W-1:0]      hit_val_ff;
   logic                   vic_found_ff;
   logic [IdxW-1:0]        vic_slot_ff;
   logic [COUNT_WIDTH-1:0] vic_cnt_ff;
   logic [IdxW-1:0]        vic_rank_ff;
   logic                   free_found_ff;
   logic [IdxW-1:0]        free_slot_ff;

   logic                   ent_valid;
   logic [IdxW-1:0]        ent_rank;
   logic                   key_match;
   logic                   vic_better;
   logic                   free_take;

   logic [OccW-1:0]        cap_eff;
   logic                   full;
   logic                   is_set;
   logic                   do_insert;
   logic                   do_evict;
   logic                   ins_ok;
   logic                   drop_en;
   logic [IdxW-1:0]        drop_thr;
   logic [IdxW-1:0]        tgt_slot;
   logic [IdxW-1:0]        tgt_rank;
   logic                   tgt_wr;
   logic [OccW-1:0]        occ_mid;
   logic [OccW-1:0]        occ_in;
   logic [COUNT_WIDTH-1:0] cnt_wdata;
   logic                   key_we;
   logic                   val_we;
   logic                   cnt_we;
   rsp_type                rsp_in;

   // scan evaluation of one entry
   always_comb begin
      ent_valid  = valid_ff[ev_idx_ff];
      ent_rank   = rank_ff[ev_idx_ff];
      key_match  = ent_valid && (key_rd_ff == req_ff.key);
      vic_better = ent_valid &&
                   (!vic_found_ff || (cnt_rd_ff < vic_cnt_ff) ||
                    ((cnt_rd_ff == vic_cnt_ff) && (ent_rank < vic_rank_ff)));
      free_take  = !ent_valid && !free_found_ff;
   end

   // decision at finish
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = OccW'(1);
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         cap_eff = OccW'(ENTRIES);
      end else begin
         cap_eff = OccW'(cap_ff);
      end
      full      = (occ_ff >= cap_eff);
      is_set    = (req_ff.mode == MODE_SET);
      do_insert = !hit_ff && is_set;
      do_evict  = do_insert && full && vic_found_ff;
      ins_ok    = do_insert && (do_evict || free_found_ff);
      drop_en   = hit_ff || do_evict;
      drop_thr  = hit_ff ? hit_rank_ff : vic_rank_ff;
      occ_mid   = occ_ff - OccW'(do_evict);
      occ_in    = occ_mid + OccW'(ins_ok);
      tgt_wr    = hit_ff || ins_ok;

      if (hit_ff) begin
         tgt_slot = hit_slot_ff;
         tgt_rank = IdxW'(occ_ff - OccW'(1));
      end else begin
         if (do_evict && (!free_found_ff || (vic_slot_ff < free_slot_ff))) begin
            tgt_slot = vic_slot_ff;
         end else begin
            tgt_slot = free_slot_ff;
         end
         tgt_rank = IdxW'(occ_mid);
      end

      if (hit_ff) begin
         cnt_wdata = (hit_cnt_ff == CountMax) ? CountMax : hit_cnt_ff + CountOne;
      end else begin
         cnt_wdata = CountOne;
      end

      key_we = cmd.finish && ins_ok;
      val_we = cmd.finish && (ins_ok || (hit_ff && is_set));
      cnt_we = cmd.finish && tgt_wr;

      rsp_in.hit        = hit_ff;
      rsp_in.read_value = (hit_ff && !is_set) ? hit_val_ff : '0;
      rsp_in.evicted    = do_evict;
   end

   // memories: one read port for the scan, one write port for the update
   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         key_rd_ff <= key_mem[scan_addr];
         val_rd_ff <= val_mem[scan_addr];
         cnt_rd_ff <= cnt_mem[scan_addr];
      end
      if (key_we) begin
         key_mem[tgt_slot] <= req_ff.key;
      end
      if (val_we) begin
         val_mem[tgt_slot] <= req_ff.value;
      end
      if (cnt_we) begin
         cnt_mem[tgt_slot] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff <= cmd.scan_rd;
      end
      ev_idx_ff <= scan_addr;
      if (cmd.start) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff        <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.start) begin
         hit_ff        <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (ev_valid_ff) begin
         if (key_match && !hit_ff) begin
            hit_ff      <= 1'b1;
            hit_slot_ff <= ev_idx_ff;
            hit_cnt_ff  <= cnt_rd_ff;
            hit_rank_ff <= ent_rank;
            hit_val_ff  <= val_rd_ff;
         end
         if (vic_better) begin
            vic_found_ff <= 1'b1;
            vic_slot_ff  <= ev_idx_ff;
            vic_cnt_ff   <= cnt_rd_ff;
            vic_rank_ff  <= ent_rank;
         end
         if (free_take) begin
            free_found_ff <= 1'b1;
            free_slot_ff  <= ev_idx_ff;
         end
      end
   end

   // rank cells: drop ranks above the threshold, place the target on top
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (tgt_wr && (IdxW'(i) == tgt_slot)) begin
               rank_ff[i] <= tgt_rank;
            end else if (drop_en && valid_ff[i] && (rank_ff[i] > drop_thr)) begin
               rank_ff[i] <= rank_ff[i] - IdxW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         if (cmd.cfg_wr) begin
            cap_ff <= csr_data;
         end
         if (cmd.finish) begin
            occ_ff <= occ_in;
            if (do_evict) begin
               valid_ff[vic_slot_ff] <= 1'b0;
            end
            if (ins_ok) begin
               valid_ff[tgt_slot] <= 1'b1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.rsp_pending = rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;

endmodule

`default_nettype wire

// File: design/lfu_cache_table.sv
// lfu_cache_table: fully associative LFU key/value cache, LRU tie-break.
// Each beat scans the key/value/count memories one entry per cycle, then
// drains and finishes into the result register, finish holding while a
// stalled response waits; a new beat is taken only after the last finishes.
// Reset: table empty (valid cells and occupancy cleared), capacity 16,
// no clearing pass; a pending response may wait while the next beat is taken.
`default_nettype none

module lfu_cache_table #(
   parameter  int ENTRIES     = lfu_pkg::ENTRIES_DEF,
   parameter  int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lfu_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lfu_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lfu_pkg::CFG_W-1:0]  csr_data
);
   import lfu_pkg::*;

   localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   ctl_cmd_type     cmd;
   dp_status_type   status;
   logic [IdxW-1:0] scan_addr;

   lfu_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd),
      .scan_addr (scan_addr)
   );

   lfu_dpath #(
      .ENTRIES     (ENTRIES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .scan_addr (scan_addr),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_data  (csr_data)
   );

   a_finish_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid && rsp_stall))
      else $error("response overwritten while stalled");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("response raised without a finished beat");

   a_start_scans_from_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (cmd.scan_rd && (scan_addr == '0)))
      else $error("scan did not start at entry zero");

   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_rd || cmd.finish) |-> (!cmd.start && !cmd.cfg_wr))
      else $error("beat or write taken while busy");

endmodule

`default_nettype wire

// File: bench/lfu_cache_table_checker.sv
// lfu_cache_table_checker: watches the request, response and csr channels of
// lfu_cache_table, predicts every response and compares it field by field.
// Depends on lfu_pkg for the beat types and widths.
module lfu_cache_table_checker #(
   parameter int ENTRIES     = lfu_pkg::ENTRIES_DEF,
   parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  lfu_pkg::req_type           req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  lfu_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [lfu_pkg::CFG_W-1:0]  csr_data,
   output int                         error_count,
   output int                         pending_count
);
   import lfu_pkg::*;

   logic [DATA_W-1:0]      slot_key   [ENTRIES];
   logic [DATA_W-1:0]      slot_value [ENTRIES];
   logic [COUNT_WIDTH-1:0] slot_count [ENTRIES];
   int                     slot_rank  [ENTRIES];
   bit                     slot_live  [ENTRIES];
   int                     fill;
   logic [CFG_W-1:0]       capacity;
   rsp_type                predicted_rsp [$];
   int                     mismatches;

   initial begin
      error_count   = 0;
      pending_count = 0;
      mismatches    = 0;
   end

   function automatic void close_rank_gap(input int gap);
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_live[i] && slot_rank[i] > gap) begin
            slot_rank[i]--;
         end
      end
   endfunction

   function automatic void promote(input int s);
      if (slot_count[s] != '1) begin
         slot_count[s]++;
      end
      close_rank_gap(slot_rank[s]);
      slot_rank[s] = fill - 1;
   endfunction

   function automatic rsp_type cache_access(input req_type item);
      rsp_type res;
      int      found;
      int      victim;
      int      limit;
      bit      placed;
      res    = '0;
      found  = -1;
      victim = -1;
      placed = 1'b0;
      limit  = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : int'(capacity));
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && slot_live[i] && slot_key[i] == item.key) begin
            found = i;
         end
      end
      if (found >= 0) begin
         res.hit = 1'b1;
         if (item.mode == MODE_GET) begin
            res.read_value = slot_value[found];
         end else begin
            slot_value[found] = item.value;
         end
         promote(found);
      end else if (item.mode == MODE_SET) begin
         if (fill >= limit) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_live[i] && (victim < 0 || slot_count[i] < slot_count[victim] ||
                   (slot_count[i] == slot_count[victim] &&
                    slot_rank[i] < slot_rank[victim]))) begin
                  victim = i;
               end
            end
            if (victim >= 0) begin
               slot_live[victim] = 1'b0;
               close_rank_gap(slot_rank[victim]);
               fill--;
               res.evicted = 1'b1;
            end
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (!placed && !slot_live[i]) begin
               placed        = 1'b1;
               slot_live[i]  = 1'b1;
               slot_key[i]   = item.key;
               slot_value[i] = item.value;
               slot_count[i] = COUNT_WIDTH'(1);
               slot_rank[i]  = fill;
               fill++;
            end
         end
      end
      return res;
   endfunction

   task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: rsp %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_live[i] = 1'b0;
         end
         fill     = 0;
         capacity = CAP_RESET;
         predicted_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            capacity = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               mismatches++;
               $display("%0t: rsp beat with none expected, actual %h", $time, rsp_data);
            end else begin
               want = predicted_rsp.pop_front();
               check_field("hit", DATA_W'(want.hit), DATA_W'(rsp_data.hit));
               check_field("read_value", want.read_value, rsp_data.read_value);
               check_field("evicted", DATA_W'(want.evicted), DATA_W'(rsp_data.evicted));
            end
         end
         if (req_valid && !req_stall) begin
            predicted_rsp.push_back(cache_access(req_data));
         end
      end
      error_count   <= mismatches;
      pending_count <= predicted_rsp.size();
   end

endmodule

// File: bench/lfu_cache_table_tb.sv
// lfu_cache_table_tb: drives lfu_cache_table with directed, hot-entry
// and random request beats over several capacities and gives the verdict.
// Depends on lfu_pkg, lfu_cache_table and lfu_cache_table_checker.
module lfu_cache_table_tb;
   import lfu_pkg::*;

   localparam int ENTRIES        = ENTRIES_DEF;
   localparam int COUNT_WIDTH    = COUNT_WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 104;
   localparam int HOT_GETS       = 32;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data  = '0;

   int               error_count;
   int               pending_count;
   int               quiet_cycles = 0;
   bit               idle_enable  = 1'b1;

   logic [CFG_W-1:0] phase_caps [0:8] = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd3,
                                          5'd8, 5'd17, 5'd12};
   logic [DATA_W-1:0] key_pool [0:18];

   lfu_cache_table #(
      .ENTRIES     (ENTRIES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   lfu_cache_table_checker #(
      .ENTRIES     (ENTRIES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= idle_enable && ($urandom_range(99) < 22);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_req(input mode_type mode, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] value);
      req_type beat;
      beat.mode  = mode;
      beat.key   = key;
      beat.value = value;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_gap();
      if (idle_enable && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CFG_W-1:0] cap);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [DATA_W-1:0] hot_key;
      logic [DATA_W-1:0] key;
      int                pool_n;
      int                limit;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_req(MODE_GET, '0, 32'd5);
      send_req(MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF);
      send_req(MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000);
      send_req(MODE_SET, '0, '0);
      send_req(MODE_SET, '1, '1);
      send_req(MODE_GET, 32'h8000_0000, '0);
      send_req(MODE_GET, 32'h7FFF_FFFF, '1);
      send_req(MODE_SET, 32'h8000_0000, 32'h1234_5678);
      send_req(MODE_GET, 32'h8000_0000, '0);
      for (int k = 1; k <= 13; k++) begin
         send_req(MODE_SET, DATA_W'(k), DATA_W'(k * 32'h0101_0101));
         idle_gap();
      end
      set_capacity(5'd2);
      send_req(MODE_SET, 32'd100, 32'hAAAA_5555);
      set_capacity(5'd0);
      send_req(MODE_SET, 32'd200, 32'h5555_AAAA);
      send_req(MODE_GET, 32'd100, '0);

      // raise one entry's count, then show it outlives a fresh key
      idle_enable <= 1'b0;
      set_capacity(5'd2);
      hot_key = $urandom;
      send_req(MODE_SET, hot_key, $urandom);
      repeat (HOT_GETS) send_req(MODE_GET, hot_key, $urandom);
      send_req(MODE_SET, hot_key ^ 32'h1, $urandom);
      send_req(MODE_SET, hot_key ^ 32'h2, $urandom);
      send_req(MODE_GET, hot_key, '0);

      for (int p = 0; p < 9; p++) begin
         idle_enable <= (p != 6);
         set_capacity(phase_caps[p]);
         limit  = (phase_caps[p] == 0) ? 1 :
                  ((phase_caps[p] > ENTRIES) ? ENTRIES : int'(phase_caps[p]));
         pool_n = limit + 3;
         for (int i = 0; i < pool_n; i++) begin
            case ($urandom_range(7))
               0:       key_pool[i] = 32'h8000_0000;
               1:       key_pool[i] = 32'h7FFF_FFFF;
               2:       key_pool[i] = '0;
               3:       key_pool[i] = '1;
               default: key_pool[i] = $urandom;
            endcase
         end
         repeat (PHASE_ITEMS) begin
            key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)]
                                            : DATA_W'($urandom);
            send_req(mode_type'($urandom_range(1)), key, $urandom);
            idle_gap();
         end
      end

      drain_results();
      repeat (ENTRIES + 8) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: lfu_cache_table.f
design/lfu_pkg.sv
design/lfu_ctrl.sv
design/lfu_dpath.sv
design/lfu_cache_table.sv
bench/lfu_cache_table_checker.sv
bench/lfu_cache_table_tb.sv
